FILE: hdl/drm_pkg.sv
// Shared constants for the diode / resistance meter datapath.
// No dependencies; used by every file under hdl.
package drm_pkg;

	localparam int unsigned MV_W    = 13;
	localparam int unsigned REG_W   = 16;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned DROP_W  = 16;
	localparam int unsigned RES_W   = 24;
	localparam int unsigned LED_W   = 3;
	localparam int unsigned IN_W    = 32;
	localparam int unsigned OUT_W   = 48;

	// current datapath widths
	localparam int unsigned CUR_W   = 33;
	localparam int unsigned IPD_W   = 10;
	localparam int unsigned LOSS_NW = 50;
	localparam int unsigned SCALE_W = 17;
	localparam int unsigned RES_NW  = 34;

	localparam logic [IDX_W-1:0] REG_PULLUP = 2'd0;
	localparam logic [IDX_W-1:0] REG_CAL    = 2'd1;
	localparam logic [IDX_W-1:0] REG_SERIES = 2'd2;

	localparam logic [REG_W-1:0] PULLUP_RST = 16'd33160;
	localparam logic [REG_W-1:0] CAL_RST    = 16'd256;
	localparam logic [REG_W-1:0] SERIES_RST = 16'd7500;

	localparam logic [SCALE_W-1:0] SCALE     = 17'd100000;
	localparam logic [SCALE_W-1:0] SCALE_HLF = 17'd50000;
	localparam logic [15:0]        RECIP10   = 16'd52429; // x/10 == x*RECIP10 >> 19
	localparam logic [RES_W-1:0]   RES_MAX   = 24'd9999999;

	// 100000 = 32 * 3125; t/3125 == t*LOSS_RECIP >> 39 for t < 2^27
	localparam logic [11:0] LOSS_DEN   = 12'd3125;
	localparam logic [27:0] LOSS_RECIP = 28'd175921861;

	localparam logic [LED_W-1:0] LED_NONE   = 3'd0;
	localparam logic [LED_W-1:0] LED_RED    = 3'd4;
	localparam logic [LED_W-1:0] LED_GREEN  = 3'd2;
	localparam logic [LED_W-1:0] LED_ORANGE = 3'd1;

endpackage

FILE: hdl/drm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband, and a
// six-stage reciprocal divider by 100000. Depends on drm_pkg.
module drm_div #(
	parameter int unsigned NW = 34,
	parameter int unsigned DW = 16,
	parameter int unsigned PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [PW-1:0] side_out
);

	logic          vld_s  [NW+1];
	logic [NW-1:0] num_s  [NW+1];
	logic [NW-1:0] quo_s  [NW+1];
	logic [DW-1:0] rem_s  [NW+1];
	logic [DW-1:0] den_s  [NW+1];
	logic [PW-1:0] side_s [NW+1];

	assign vld_s[0]  = in_valid;
	assign num_s[0]  = num;
	assign quo_s[0]  = '0;
	assign rem_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0]   trial;
		logic [DW+1:0] sub;
		logic          ge;

		assign trial = {rem_s[i], num_s[i][NW-1]};
		assign sub   = {1'b0, trial} - {2'b00, den_s[i]};
		assign ge    = ~sub[DW+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i+1]  <= num_s[i] << 1;
				quo_s[i+1]  <= {quo_s[i][NW-2:0], ge};
				rem_s[i+1]  <= ge ? sub[DW-1:0] : trial[DW-1:0];
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign quo       = quo_s[NW];
	assign side_out  = side_s[NW];

endmodule

// Low 16 bits of num / 100000: drop the factor 32 by a shift, then divide by 3125
// in three 15-bit digits, each by reciprocal multiply and remainder fix-up.
module drm_div_scale #(
	parameter int unsigned PW = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [drm_pkg::LOSS_NW-1:0] num,
	input  logic [PW-1:0]               side_in,
	output logic                        out_valid,
	output logic [15:0]                 quo,
	output logic [PW-1:0]               side_out
);

	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [PW-1:0] side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [14:0]   t0_s1, t0_s2;
	logic [29:0]   lo_s1, lo_s2;
	logic [42:0]   p0_s2;
	logic [26:0]   t1_s3, t1_s4;
	logic [14:0]   lo_s3, lo_s4;
	logic [54:0]   p1_s4;
	logic [26:0]   t2_s5;
	logic          q1b_s5, q1b_s6;
	logic [54:0]   p2_s6;
	logic [3:0]    q0;
	logic [14:0]   r0;
	logic [14:0]   q1;
	logic [26:0]   r1;

	// remainders stay below 3125, so 12 bits carry them into the next digit
	assign q0 = p0_s2[42:39];
	assign r0 = t0_s2 - ({11'd0, q0} * {3'd0, drm_pkg::LOSS_DEN});
	assign q1 = p1_s4[53:39];
	assign r1 = t1_s4 - ({12'd0, q1} * {15'd0, drm_pkg::LOSS_DEN});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			t0_s1   <= num[49:35];
			lo_s1   <= num[34:5];

			side_s2 <= side_s1;
			t0_s2   <= t0_s1;
			lo_s2   <= lo_s1;
			p0_s2   <= t0_s1 * drm_pkg::LOSS_RECIP;

			side_s3 <= side_s2;
			t1_s3   <= {r0[11:0], lo_s2[29:15]};
			lo_s3   <= lo_s2[14:0];

			side_s4 <= side_s3;
			t1_s4   <= t1_s3;
			lo_s4   <= lo_s3;
			p1_s4   <= t1_s3 * drm_pkg::LOSS_RECIP;

			side_s5 <= side_s4;
			t2_s5   <= {r1[11:0], lo_s4};
			q1b_s5  <= q1[0];

			side_s6 <= side_s5;
			q1b_s6  <= q1b_s5;
			p2_s6   <= t2_s5 * drm_pkg::LOSS_RECIP;
		end
	end

	assign out_valid = v_s6;
	assign quo       = {q1b_s6, p2_s6[53:39]};
	assign side_out  = side_s6;

endmodule

FILE: hdl/diode_resistance_meter_unit.sv
// Top level of the diode / resistance meter: config registers, arithmetic stages,
// two drm_div dividers, a drm_div_scale and the output register.
// Depends on drm_pkg, drm_div, drm_div_scale.

// Takes one probe/supply pair per cycle unless the output stalls, and returns one result
// per pair, in order. The path runs through the two bit-serial divider pipelines (33
// and 34 stages), the six-stage divide by 100000 and the arithmetic stages between
// them. The whole pipe advances whenever the output register is empty or taken, so
// s_tready follows m_tready; a stall holds every stage. Configuration writes are meant
// for idle.
module diode_resistance_meter_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [drm_pkg::IN_W-1:0]  s_tdata,  // probe_mv[12:0], supply_mv[25:13], zeros
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [drm_pkg::OUT_W-1:0] m_tdata,  // drop_mv[15:0], resistance_ohms[39:16],
	                                            // led_code[42:40], zeros
	input  logic                      cfg_we,
	input  logic [drm_pkg::IDX_W-1:0] cfg_index,
	input  logic [drm_pkg::REG_W-1:0] cfg_data
);

	localparam int unsigned MW = drm_pkg::MV_W;
	localparam int unsigned CW = drm_pkg::CUR_W;
	localparam int unsigned IW = drm_pkg::IPD_W;

	logic [drm_pkg::REG_W-1:0] pullup_q, cal_q, series_q, rpu;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pullup_q <= drm_pkg::PULLUP_RST;
			cal_q    <= drm_pkg::CAL_RST;
			series_q <= drm_pkg::SERIES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				drm_pkg::REG_PULLUP: pullup_q <= cfg_data;
				drm_pkg::REG_CAL:    cal_q    <= cfg_data;
				drm_pkg::REG_SERIES: series_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rpu      = (pullup_q == '0) ? 16'd1 : pullup_q;
	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;

	// stage 1: supply correction product, pull-down current product
	logic          v_s1;
	logic [MW-1:0] probe_s1, vcc_s1;
	logic [28:0]   corr_s1;
	logic [29:0]   ipdp_s1;
	logic [MW-1:0] in_probe, in_vcc;

	assign in_probe = s_tdata[MW-1:0];
	assign in_vcc   = s_tdata[2*MW-1:MW];

	// stage 2
	logic          v_s2;
	logic [MW-1:0] probe_s2, vcc_s2;
	logic [15:0]   diff_s2;
	logic [IW-1:0] ipd_s2;
	logic [28:0]   corr_rnd;
	logic [15:0]   vccm;

	assign corr_rnd = corr_s1 + 29'd128;
	assign vccm = (probe_s1 < (vcc_s1 >> 1)) ? {3'b000, vcc_s1} : corr_rnd[23:8];

	// stage 3: pull-up current numerator
	logic          v_s3;
	logic [CW-1:0] num1_s3;
	logic [2*MW+IW-1:0] side1_s3;

	// divider 1 output
	logic          v_d1;
	logic [CW-1:0] irpu;
	logic [2*MW+IW-1:0] side1_d1;

	// stage 4: device current
	logic          v_s4;
	logic [MW-1:0] probe_s4, vcc_s4;
	logic [CW-1:0] idut_s4;
	logic [IW-1:0] ipd_d1;

	assign ipd_d1 = side1_d1[IW-1:0];

	// stage 5: series loss product
	logic          v_s5;
	logic [MW-1:0] probe_s5, vcc_s5;
	logic [CW-1:0] idut_s5;
	logic [48:0]   prods_s5;

	logic          v_d2;
	logic [15:0]   q2;
	logic [2*MW+CW-1:0] side2_d2;
	logic [MW-1:0] probe_d2, vcc_d2;
	logic [CW-1:0] idut_d2;

	assign {probe_d2, vcc_d2, idut_d2} = side2_d2;

	// stage 6: drop
	logic          v_s6;
	logic [15:0]   draw_s6;
	logic [MW-1:0] vcc_s6;
	logic [CW-1:0] idut_s6;

	// stage 7: resistance numerator product
	logic          v_s7;
	logic [15:0]   draw_s7;
	logic [MW-1:0] vcc_s7;
	logic [CW-1:0] idut_s7;
	logic [31:0]   prodr_s7;

	logic          v_d3;
	logic [drm_pkg::RES_NW-1:0] q3;
	logic [15+MW:0] side3_d3;
	logic [15:0]   draw_d3;
	logic [MW-1:0] vcc_d3;

	assign {draw_d3, vcc_d3} = side3_d3;

	// output stage
	logic [drm_pkg::RES_W-1:0] res;
	logic [drm_pkg::LED_W-1:0] led;
	logic signed [16:0] drop_x, top_x;

	assign drop_x = {draw_d3[15], draw_d3};
	assign top_x  = $signed({4'b0000, vcc_d3}) - 17'sd500;

	always_comb begin
		if (draw_d3[15]) begin
			res = '0;
		end else if (q3 > {10'd0, drm_pkg::RES_MAX}) begin
			res = drm_pkg::RES_MAX;
		end else begin
			res = q3[drm_pkg::RES_W-1:0];
		end
		priority if (drop_x < -17'sd100) begin
			led = drm_pkg::LED_NONE;
		end else if (drop_x < 17'sd100) begin
			led = drm_pkg::LED_RED;
		end else if (drop_x < 17'sd1000) begin
			led = drm_pkg::LED_GREEN;
		end else if (drop_x < top_x) begin
			led = drm_pkg::LED_ORANGE;
		end else begin
			led = drm_pkg::LED_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1     <= s_tvalid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_d1;
			v_s5     <= v_s4;
			v_s6     <= v_d2;
			v_s7     <= v_s6;
			m_tvalid <= v_d3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			probe_s1 <= in_probe;
			vcc_s1   <= in_vcc;
			corr_s1  <= in_vcc * cal_q;
			ipdp_s1  <= ({1'b0, in_probe} + 14'd5) * drm_pkg::RECIP10;

			probe_s2 <= probe_s1;
			vcc_s2   <= vcc_s1;
			diff_s2  <= (vccm >= {3'b000, probe_s1}) ? vccm - {3'b000, probe_s1} : 16'd0;
			ipd_s2   <= ipdp_s1[28:19];

			num1_s3  <= diff_s2 * drm_pkg::SCALE + {17'd0, rpu >> 1};
			side1_s3 <= {probe_s2, vcc_s2, ipd_s2};

			{probe_s4, vcc_s4} <= side1_d1[2*MW+IW-1:IW];
			idut_s4  <= (irpu >= {23'd0, ipd_d1}) ? irpu - {23'd0, ipd_d1} : '0;

			probe_s5 <= probe_s4;
			vcc_s5   <= vcc_s4;
			idut_s5  <= idut_s4;
			prods_s5 <= idut_s4 * series_q;

			draw_s6  <= {3'b000, probe_d2} - q2;
			vcc_s6   <= vcc_d2;
			idut_s6  <= idut_d2;

			draw_s7  <= draw_s6;
			vcc_s7   <= vcc_s6;
			idut_s7  <= idut_s6;
			prodr_s7 <= draw_s6[14:0] * drm_pkg::SCALE;

			m_tdata  <= {5'd0, led, res, draw_d3};
		end
	end

	drm_div #(.NW(CW), .DW(drm_pkg::REG_W), .PW(2*MW+IW)) u_div_pullup (
		.clk, .arst_n, .en,
		.in_valid (v_s3),
		.num      (num1_s3),
		.den      (rpu),
		.side_in  (side1_s3),
		.out_valid(v_d1),
		.quo      (irpu),
		.side_out (side1_d1)
	);

	drm_div_scale #(.PW(2*MW+CW)) u_div_loss (
		.clk, .arst_n, .en,
		.in_valid (v_s5),
		.num      ({1'b0, prods_s5} + {33'd0, drm_pkg::SCALE_HLF}),
		.side_in  ({probe_s5, vcc_s5, idut_s5}),
		.out_valid(v_d2),
		.quo      (q2),
		.side_out (side2_d2)
	);

	drm_div #(.NW(drm_pkg::RES_NW), .DW(CW), .PW(16+MW)) u_div_res (
		.clk, .arst_n, .en,
		.in_valid (v_s7),
		.num      ({2'b00, prodr_s7} + {1'b0, idut_s7[CW-1:1]}),
		.den      (idut_s7),
		.side_in  ({draw_s7, vcc_s7}),
		.out_valid(v_d3),
		.quo      (q3),
		.side_out (side3_d3)
	);

endmodule

FILE: hdl/drm_check.sv
// Port-level checks for diode_resistance_meter_unit, attached by bind.
// Depends on drm_pkg.
module drm_check (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [drm_pkg::OUT_W-1:0] m_tdata
);

	// a stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// taking the output always frees the input side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked while output taken");

	a_res_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:16] <= drm_pkg::RES_MAX)
		else $error("resistance above limit");

	a_neg_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15] |-> m_tdata[39:16] == '0)
		else $error("negative drop with nonzero resistance");

	a_led: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[42:40] == drm_pkg::LED_NONE ||
			m_tdata[42:40] == drm_pkg::LED_RED ||
			m_tdata[42:40] == drm_pkg::LED_GREEN ||
			m_tdata[42:40] == drm_pkg::LED_ORANGE)
		else $error("bad led code");

endmodule

bind diode_resistance_meter_unit drm_check u_drm_check (
	.clk, .arst_n, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

FILE: tb/sv/tb_top.sv
// Testbench for diode_resistance_meter_unit: streams probe/supply pairs, predicts
// drop, resistance and LED code per item and checks them in order.
// Depends on drm_pkg and the unit RTL.
`timescale 1ns / 1ps

class meter_scoreboard;
	typedef struct packed {
		logic [15:0] drop;
		logic [23:0] res;
		logic [2:0]  led;
	} meter_result_t;

	meter_result_t pending_q[$];
	int            mismatches;
	int            unexpected;

	function void note_item(logic [12:0] probe, logic [12:0] vcc,
	                        logic [15:0] rpu_reg, logic [15:0] cal,
	                        logic [15:0] rser);
		longint unsigned rpu, vccm, irpu, ipd, idut, loss, rdut;
		logic [15:0]     draw;
		int              udut;
		meter_result_t   r;
		rpu = (rpu_reg == 0) ? 1 : rpu_reg;
		vccm = ((longint'(vcc) * cal + 128) / 256) & 16'hFFFF;
		if (probe < vcc / 2)
			vccm = vcc;
		irpu = 0;
		if (vccm >= probe)
			irpu = ((vccm - probe) * 100000 + rpu / 2) / rpu;
		ipd = (probe + 5) / 10;
		idut = (irpu >= ipd) ? irpu - ipd : 0;
		loss = ((idut * rser + 50000) / 100000) & 16'hFFFF;
		draw = 16'(probe - loss);
		udut = int'($signed(draw));
		if (udut < 0)
			rdut = 0;
		else if (idut == 0)
			rdut = drm_pkg::RES_MAX;
		else begin
			rdut = (longint'(udut) * 100000 + idut / 2) / idut;
			if (rdut > drm_pkg::RES_MAX)
				rdut = drm_pkg::RES_MAX;
		end
		if (udut < -100)
			r.led = drm_pkg::LED_NONE;
		else if (udut < 100)
			r.led = drm_pkg::LED_RED;
		else if (udut < 1000)
			r.led = drm_pkg::LED_GREEN;
		else if (udut < int'(vcc) - 500)
			r.led = drm_pkg::LED_ORANGE;
		else
			r.led = drm_pkg::LED_NONE;
		r.drop = draw;
		r.res = rdut[23:0];
		pending_q.push_back(r);
	endfunction

	function void check_result(logic [47:0] data);
		meter_result_t e;
		if (pending_q.size() == 0) begin
			unexpected++;
			if (mismatches + unexpected <= 10)
				$display("unexpected result %h", data);
			return;
		end
		e = pending_q.pop_front();
		if (data[15:0] !== e.drop || data[39:16] !== e.res || data[42:40] !== e.led
		    || data[47:43] !== 5'd0) begin
			mismatches++;
			if (mismatches + unexpected <= 10)
				$display("mismatch: drop %0d/%0d res %0d/%0d led %0d/%0d (exp/act)",
				         $signed(e.drop), $signed(data[15:0]), e.res, data[39:16],
				         e.led, data[42:40]);
		end
	endfunction
endclass

module tb_top;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [drm_pkg::IN_W-1:0]  s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [drm_pkg::OUT_W-1:0] m_tdata;
	logic                      cfg_we = 1'b0;
	logic [drm_pkg::IDX_W-1:0] cfg_index = '0;
	logic [drm_pkg::REG_W-1:0] cfg_data = '0;

	logic [15:0] pullup_r = drm_pkg::PULLUP_RST;
	logic [15:0] cal_r = drm_pkg::CAL_RST;
	logic [15:0] series_r = drm_pkg::SERIES_RST;
	int          send_idle_pct = 0, recv_stall_pct = 0;
	bit          hold_off = 1'b0;
	meter_scoreboard board = new();

	diode_resistance_meter_unit dut (.*);

	initial forever #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_pair(logic [12:0] probe, logic [12:0] vcc);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, vcc, probe};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_item(probe, vcc, pullup_r, cal_r, series_r);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending_q.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(logic [drm_pkg::IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			drm_pkg::REG_PULLUP: pullup_r = val;
			drm_pkg::REG_CAL:    cal_r = val;
			default:             series_r = val;
		endcase
	endtask

	// mostly realistic pairs: probe usually at or below supply
	task automatic send_random(int n);
		logic [12:0] p, v;
		for (int i = 0; i < n; i++) begin
			v = 13'($urandom_range(8191));
			case ($urandom_range(3))
				0: p = 13'($urandom_range(8191));
				1: p = 13'($urandom_range(v));
				2: p = (v > 40) ? 13'(v - $urandom_range(40)) : v;
				default: p = 13'($urandom_range(v / 2 + 50 > 8191 ? 8191 : v / 2 + 50));
			endcase
			send_pair(p, v);
		end
	endtask

	initial begin
		int unsigned cfgs[6][3] = '{
			'{33160, 256, 7500}, '{1, 0, 0}, '{65535, 65535, 65535},
			'{0, 300, 100}, '{1000, 200, 65535}, '{47000, 512, 1}};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: field extremes and special cases at reset settings
		send_pair(13'd0, 13'd0);
		send_pair(13'd8191, 13'd8191);
		send_pair(13'd8191, 13'd0);
		send_pair(13'd0, 13'd8191);
		send_pair(13'd1000, 13'd5000);
		send_pair(13'd2499, 13'd5000);
		send_pair(13'd2500, 13'd5000);
		send_pair(13'd5001, 13'd5000);
		send_pair(13'd700, 13'd5000);
		send_pair(13'd4990, 13'd5000);
		send_pair(13'd50, 13'd5000);
		send_pair(13'd4000, 13'd4200);
		send_pair(13'h0AAA, 13'h1555);
		send_pair(13'h1555, 13'h0AAA);
		drain();
		for (int c = 0; c < 6; c++) begin
			write_reg(drm_pkg::REG_PULLUP, 16'(cfgs[c][0]));
			write_reg(drm_pkg::REG_CAL, 16'(cfgs[c][1]));
			write_reg(drm_pkg::REG_SERIES, 16'(cfgs[c][2]));
			send_idle_pct = 0; recv_stall_pct = 0;
			send_random(50);
			send_idle_pct = 79;
			send_random(45);
			send_idle_pct = 0; recv_stall_pct = 79;
			send_random(45);
			send_idle_pct = 10; recv_stall_pct = 10;
			send_random(35);
			if (c == 2) begin
				// long receiver hold-off while the sender keeps offering
				fork
					begin
						hold_off = 1'b1;
						repeat (400) @(posedge clk);
						hold_off = 1'b0;
					end
					send_random(200);
				join
			end
			drain();
		end
		if (board.mismatches == 0 && board.unexpected == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
